// ===== rtl/cpfc_pkg.sv =====
package cpfc_pkg;

  localparam int unsigned SITE_W    = 12;
  localparam int unsigned XW        = 3;
  localparam int unsigned ROW_W     = 9;
  localparam int unsigned HGT_W     = 10;
  localparam int unsigned HARM_W    = 4;
  localparam int unsigned NHARM     = 16;
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned COS_W     = 16;
  localparam int unsigned TERM_W    = COS_W + 1;
  localparam int unsigned MAX_SITES = 4096;
  localparam int unsigned ADDR_W    = 12;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned MAX_HEIGHT = 512;
  localparam int unsigned HALF_ROWS = MAX_HEIGHT / 2 + 1;
  localparam int unsigned ROWBITS   = NHARM * SUM_W;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_Y2,
    BK_PAIR,
    BK_DRAIN,
    BK_READ
  } back_state_e;

  // queued request
  typedef struct packed {
    cmd_e               cmd;
    logic [SITE_W-1:0]  site;
    logic               last;
    logic [HARM_W-1:0]  harm;
    logic [ROW_W-1:0]   dist_row;
    logic               dist_ok;
  } req_t;

  // one bin row operation
  typedef struct packed {
    logic               rd;
    logic [ROW_W-1:0]   row;
    logic [XW-1:0]      dx;
    logic               dbl;
    logic [HARM_W-1:0]  harm;
  } bin_op_t;

  // round(16384*cos(2*pi*p/8))
  function automatic logic signed [COS_W-1:0] cos_q14(input logic [XW-1:0] ph);
    logic signed [COS_W-1:0] v;
    case (ph)
      3'd0:    v = 16'sd16384;
      3'd1:    v = 16'sd11585;
      3'd2:    v = 16'sd0;
      3'd3:    v = -16'sd11585;
      3'd4:    v = -16'sd16384;
      3'd5:    v = -16'sd11585;
      3'd6:    v = 16'sd0;
      3'd7:    v = 16'sd11585;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/cpfc_front.sv =====
module cpfc_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             cmd_i,
  input  logic [11:0]            site_i,
  input  logic                   cluster_end_i,
  input  logic [3:0]             harmonic_i,
  input  logic [8:0]             distance_i,
  output logic                   req_valid_o,
  output cpfc_pkg::req_t         req_o,
  input  logic                   req_pop_i
);
  import cpfc_pkg::*;

  req_t       fifo_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  req_t       req_new;
  logic       push;

  always_comb begin
    req_new.cmd      = cmd_e'(cmd_i);
    req_new.site     = site_i;
    req_new.last     = cluster_end_i;
    req_new.harm     = harmonic_i;
    req_new.dist_row = distance_i;
    req_new.dist_ok  = (distance_i < ROW_W'(HALF_ROWS));
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  // unused command code is dropped here
  assign push        = in_valid_i && in_ready_o && (req_new.cmd != CMD_NONE);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = fifo_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (req_pop_i) rd_q <= ~rd_q;
      if (push && !req_pop_i) cnt_q <= cnt_q + 2'd1;
      else if (!push && req_pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= req_new;
  end

endmodule

// ===== rtl/cpfc_rowmod.sv =====
module cpfc_rowmod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [9:0]  h_i,
  input  logic        in_v_i,
  input  logic [8:0]  in_row_i,
  input  logic [2:0]  in_x_i,
  output logic        out_v_o,
  output logic [8:0]  out_row_o,
  output logic [2:0]  out_x_o,
  output logic        busy_o
);
  import cpfc_pkg::*;

  localparam int unsigned THR_W = HGT_W + ROW_W - 1;

  logic [ROW_W-1:0] rem_q [ROW_W];
  logic [ROW_W-1:0] rem_d [ROW_W];
  logic [ROW_W-1:0] rem_in [ROW_W];
  logic [XW-1:0]    x_q [ROW_W];
  logic [ROW_W-1:0] v_q;
  logic [THR_W-1:0] thr [ROW_W];

  // one restoring step per stage, quotient bit ROW_W-1-s
  always_comb begin
    for (int s = 0; s < ROW_W; s++) begin
      rem_in[s] = (s == 0) ? in_row_i : rem_q[(s == 0) ? 0 : s - 1];
      thr[s]    = THR_W'(h_i) << (ROW_W - 1 - s);
      if (THR_W'(rem_in[s]) >= thr[s]) begin
        rem_d[s] = rem_in[s] - thr[s][ROW_W-1:0];
      end else begin
        rem_d[s] = rem_in[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[ROW_W-2:0], in_v_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < ROW_W; s++) begin
      rem_q[s] <= rem_d[s];
      x_q[s]   <= (s == 0) ? in_x_i : x_q[(s == 0) ? 0 : s - 1];
    end
  end

  assign out_v_o   = v_q[ROW_W-1];
  assign out_row_o = rem_q[ROW_W-1];
  assign out_x_o   = x_q[ROW_W-1];
  assign busy_o    = |v_q;

endmodule

// ===== rtl/cpfc_bins.sv =====
module cpfc_bins (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clr_i,
  input  logic                 op_v_i,
  input  cpfc_pkg::bin_op_t    op_i,
  input  logic [3:0]           kmax_i,
  output logic                 rd_v_o,
  output logic [47:0]          rd_data_o,
  output logic                 busy_o
);
  import cpfc_pkg::*;

  logic [ROWBITS-1:0]   mem_q [HALF_ROWS];
  logic [ROWBITS-1:0]   rdata_q;
  logic [HALF_ROWS-1:0] vld_q;
  logic                 vb_q;
  logic                 sb_v_q;
  bin_op_t              sb_op_q;
  logic                 lw_v_q;
  logic [ROW_W-1:0]     lw_row_q;
  logic [ROWBITS-1:0]   lw_data_q;

  logic [ROWBITS-1:0]       old_row, new_row;
  logic [SUM_W-1:0]         old_k [NHARM];
  logic [6:0]               prod [NHARM];
  logic signed [COS_W-1:0]  cosv [NHARM];
  logic [TERM_W-1:0]        term [NHARM];
  logic [SUM_W:0]           sum [NHARM];
  logic [SUM_W-1:0]         sat [NHARM];
  logic                     wr;

  // forward the previous write, which the memory read did not see yet
  always_comb begin
    if (lw_v_q && lw_row_q == sb_op_q.row) old_row = lw_data_q;
    else if (vb_q) old_row = rdata_q;
    else old_row = '0;
  end

  always_comb begin
    for (int k = 0; k < NHARM; k++) begin
      old_k[k] = old_row[k*SUM_W +: SUM_W];
      prod[k]  = 7'(HARM_W'(k)) * 7'(sb_op_q.dx);
      cosv[k]  = cos_q14(prod[k][XW-1:0]);
      term[k]  = sb_op_q.dbl ? {cosv[k], 1'b0} : {cosv[k][COS_W-1], cosv[k]};
      sum[k]   = {old_k[k][SUM_W-1], old_k[k]}
               + {{(SUM_W+1-TERM_W){term[k][TERM_W-1]}}, term[k]};
      if (sum[k][SUM_W] != sum[k][SUM_W-1]) begin
        sat[k] = sum[k][SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        sat[k] = sum[k][SUM_W-1:0];
      end
      new_row[k*SUM_W +: SUM_W] = (HARM_W'(k) <= kmax_i) ? sat[k] : old_k[k];
    end
  end

  assign wr        = sb_v_q && !sb_op_q.rd;
  assign rd_v_o    = sb_v_q && sb_op_q.rd;
  assign rd_data_o = old_row[sb_op_q.harm*SUM_W +: SUM_W];
  assign busy_o    = sb_v_q || lw_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      sb_v_q <= 1'b0;
      lw_v_q <= 1'b0;
    end else begin
      sb_v_q <= op_v_i;
      lw_v_q <= wr;
      if (clr_i) vld_q <= '0;
      else if (wr) vld_q[sb_op_q.row] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_v_i) begin
      rdata_q <= mem_q[op_i.row];
      vb_q    <= vld_q[op_i.row];
      sb_op_q <= op_i;
    end
    if (wr) begin
      mem_q[sb_op_q.row] <= new_row;
      lw_row_q           <= sb_op_q.row;
      lw_data_q          <= new_row;
    end
  end

endmodule

// ===== rtl/cpfc_back.sv =====
module cpfc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  cpfc_pkg::req_t       req_i,
  output logic                 req_pop_o,
  input  logic [9:0]           h_i,
  input  logic [3:0]           kmax_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [47:0]          bin_sum_o,
  output logic                 sites_dropped_o
);
  import cpfc_pkg::*;

  back_state_e         state_q, state_d;
  logic [ADDR_W-1:0]   i_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                drop_q;
  logic [SITE_W-1:0]   site_q;
  logic                last_q;
  logic [ROW_W-1:0]    y2_q;
  logic [SITE_W-1:0]   smem [MAX_SITES];
  logic [SITE_W-1:0]   smem_rd_q;
  logic                rd_pend_q;
  logic                pv_q;
  bin_op_t             pop_q;
  logic                out_v_q;
  logic [SUM_W-1:0]    out_sum_q;
  logic                out_drop_q;

  logic start_add, clr, rd_issue, load_zero, smem_re, store, busy;
  logic mod_in_v, mod_out_v, mod_busy;
  logic [ROW_W-1:0] mod_in_row, mod_out_row;
  logic [XW-1:0]    mod_in_x, mod_out_x;
  logic bins_rd_v, bins_busy, bins_op_v;
  logic [SUM_W-1:0] bins_rd_data;
  bin_op_t bins_op, pair_op, self_op, read_op;
  logic signed [HGT_W:0] dy, half_s;
  logic [ROW_W-1:0] half, ady;

  assign mod_in_v   = start_add || rd_pend_q;
  assign mod_in_row = start_add ? req_i.site[SITE_W-1:XW] : smem_rd_q[SITE_W-1:XW];
  assign mod_in_x   = start_add ? req_i.site[XW-1:0] : smem_rd_q[XW-1:0];

  cpfc_rowmod u_rowmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .h_i       (h_i),
    .in_v_i    (mod_in_v),
    .in_row_i  (mod_in_row),
    .in_x_i    (mod_in_x),
    .out_v_o   (mod_out_v),
    .out_row_o (mod_out_row),
    .out_x_o   (mod_out_x),
    .busy_o    (mod_busy)
  );

  // fold periodic row distance into 0..h/2
  always_comb begin
    half   = h_i[HGT_W-1:1];
    half_s = (HGT_W+1)'(half);
    dy     = (HGT_W+1)'(y2_q) - (HGT_W+1)'(mod_out_row);
    if (dy < -half_s) dy = dy + (HGT_W+1)'(h_i);
    else if (dy > half_s) dy = dy - (HGT_W+1)'(h_i);
    ady = dy[HGT_W] ? ROW_W'(-dy) : ROW_W'(dy);
    pair_op.rd   = 1'b0;
    pair_op.row  = ady;
    pair_op.dx   = site_q[XW-1:0] - mod_out_x;
    pair_op.dbl  = (ady == '0) || (ady == half);
    pair_op.harm = '0;
    self_op      = '0;
    read_op.rd   = 1'b1;
    read_op.row  = req_i.dist_row;
    read_op.dx   = '0;
    read_op.dbl  = 1'b0;
    read_op.harm = req_i.harm;
  end

  assign bins_op_v = pv_q || rd_issue;
  assign bins_op   = rd_issue ? read_op : pop_q;

  cpfc_bins u_bins (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (clr),
    .op_v_i    (bins_op_v),
    .op_i      (bins_op),
    .kmax_i    (kmax_i),
    .rd_v_o    (bins_rd_v),
    .rd_data_o (bins_rd_data),
    .busy_o    (bins_busy)
  );

  assign busy = rd_pend_q || mod_busy || pv_q || bins_busy;

  always_comb begin
    state_d   = state_q;
    req_pop_o = 1'b0;
    start_add = 1'b0;
    clr       = 1'b0;
    rd_issue  = 1'b0;
    load_zero = 1'b0;
    smem_re   = 1'b0;
    store     = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (req_valid_i) begin
          case (req_i.cmd)
            CMD_CLEAR: begin
              req_pop_o = 1'b1;
              clr       = 1'b1;
            end
            CMD_ADD: begin
              req_pop_o = 1'b1;
              start_add = 1'b1;
              state_d   = BK_Y2;
            end
            CMD_READ: begin
              if (!out_v_q) begin
                req_pop_o = 1'b1;
                if (req_i.dist_ok) begin
                  rd_issue = 1'b1;
                  state_d  = BK_READ;
                end else begin
                  load_zero = 1'b1;
                end
              end
            end
            default: req_pop_o = 1'b1;
          endcase
        end
      end
      BK_Y2: begin
        if (mod_out_v) state_d = (cnt_q == '0) ? BK_DRAIN : BK_PAIR;
      end
      BK_PAIR: begin
        smem_re = 1'b1;
        if ({1'b0, i_q} == cnt_q - CNT_W'(1)) state_d = BK_DRAIN;
      end
      BK_DRAIN: begin
        if (!busy) begin
          store   = 1'b1;
          state_d = BK_IDLE;
        end
      end
      BK_READ: begin
        if (bins_rd_v) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      cnt_q     <= '0;
      drop_q    <= 1'b0;
      rd_pend_q <= 1'b0;
      pv_q      <= 1'b0;
      out_v_q   <= 1'b0;
      i_q       <= '0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= smem_re;
      pv_q      <= start_add || (mod_out_v && state_q != BK_Y2);
      if (state_q == BK_Y2) i_q <= '0;
      else if (smem_re) i_q <= i_q + ADDR_W'(1);
      if (clr) begin
        cnt_q  <= '0;
        drop_q <= 1'b0;
      end else if (store) begin
        if (last_q) cnt_q <= '0;
        else if (cnt_q < CNT_W'(MAX_SITES)) cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q >= CNT_W'(MAX_SITES)) drop_q <= 1'b1;
      end
      if (load_zero || (state_q == BK_READ && bins_rd_v)) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_add) begin
      site_q <= req_i.site;
      last_q <= req_i.last;
      pop_q  <= self_op;
    end else if (mod_out_v && state_q != BK_Y2) begin
      pop_q <= pair_op;
    end
    if (state_q == BK_Y2 && mod_out_v) y2_q <= mod_out_row;
    if (store && cnt_q < CNT_W'(MAX_SITES)) smem[cnt_q[ADDR_W-1:0]] <= site_q;
    if (smem_re) smem_rd_q <= smem[i_q];
    if (load_zero) begin
      out_sum_q  <= '0;
      out_drop_q <= drop_q;
    end else if (state_q == BK_READ && bins_rd_v) begin
      out_sum_q  <= bins_rd_data;
      out_drop_q <= drop_q;
    end
  end

  assign out_valid_o     = out_v_q;
  assign bin_sum_o       = out_sum_q;
  assign sites_dropped_o = out_drop_q;

endmodule

// ===== rtl/cluster_pair_fourier_correlator_top.sv =====
// add request: in the back part, one stored site paired per cycle through the site store
//   read, a 9-stage row modulo pipe and one bin row read-modify-write
// read: result held until taken
// throughput is bounded by one pair per cycle on the bin row memory port
// reset is asynchronous active low: bins read as zero through per-row valid bits,
//   no clearing pass; height 32 and harmonic limit 6 after reset
module cluster_pair_fourier_correlator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [11:0] site_i,
  input  logic        cluster_end_i,
  input  logic [3:0]  harmonic_i,
  input  logic [8:0]  distance_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [47:0] bin_sum_o,
  output logic        sites_dropped_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [9:0]  cfg_data_i
);
  import cpfc_pkg::*;

  localparam logic CFG_HEIGHT = 1'b0;
  localparam logic CFG_HLIM   = 1'b1;

  logic [HGT_W-1:0]  height_q;
  logic [HARM_W-1:0] hlim_q;
  logic [HGT_W-1:0]  h_eff;
  logic              req_valid, req_pop;
  req_t              req;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= HGT_W'(32);
      hlim_q   <= HARM_W'(6);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_HLIM:   hlim_q   <= cfg_data_i[HARM_W-1:0];
        default:    height_q <= height_q;
      endcase
    end
  end

  // height clamped to 2..512
  always_comb begin
    if (height_q < HGT_W'(2)) h_eff = HGT_W'(2);
    else if (height_q > HGT_W'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
    else h_eff = height_q;
  end

  // front: request intake and queue
  cpfc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .site_i        (site_i),
    .cluster_end_i (cluster_end_i),
    .harmonic_i    (harmonic_i),
    .distance_i    (distance_i),
    .req_valid_o   (req_valid),
    .req_o         (req),
    .req_pop_i     (req_pop)
  );

  // back: site store, pairing and bin accumulation
  cpfc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req_valid),
    .req_i           (req),
    .req_pop_o       (req_pop),
    .h_i             (h_eff),
    .kmax_i          (hlim_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .bin_sum_o       (bin_sum_o),
    .sites_dropped_o (sites_dropped_o)
  );

endmodule
